// ===== src/lj_pkg.sv =====
package lj_pkg;

  // Fixed-point format and datapath widths.
  localparam int FRAC_BITS = 16;
  localparam int R_W       = 32;
  localparam int OUT_W     = 48;
  localparam int POW_W     = 62;
  localparam int MAG_W     = 63;
  localparam int MUL_W     = 64;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SD_W      = R_W + FRAC_BITS;

  // The divider produces DIV_STEPS quotient bits, one per stage.
  localparam int DIV_STEPS = POW_W;
  localparam int S_PAD     = DIV_STEPS - SD_W;
  localparam int MUL_LAT   = 2;

  // Total register stages from input beat to output register.
  localparam int TOTAL_LAT = 1 + DIV_STEPS + 3 * MUL_LAT + 1 + MUL_LAT + 1
                             + DIV_STEPS + 1 + 1;

  localparam logic [POW_W-1:0] POW_LIMIT = {POW_W{1'b1}};
  localparam logic signed [MUL_W-1:0] OUT_MAX = MUL_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [MUL_W-1:0] OUT_MIN = -MUL_W'(64'sd1 <<< (OUT_W - 1));

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WELL_DEPTH     = 2'd0,
    REG_SIZE_SQUARED   = 2'd1,
    REG_CUTOFF_SQUARED = 2'd2,
    REG_ENERGY_OFFSET  = 2'd3
  } reg_idx_t;

  // Per-item sideband carried down the pipeline; fields fill in as stages go.
  typedef struct packed {
    logic [R_W-1:0]   r2;
    logic             beyond;
    logic             zero;
    logic             over;
    logic [SD_W-1:0]  s;
    logic [POW_W-1:0] s3;
    logic [MAG_W-1:0] me;
    logic [MAG_W-1:0] mf;
    logic             neg_e;
    logic             neg_f;
    logic [POW_W-1:0] te;
    logic             capf;
  } item_t;

endpackage

// ===== src/lj_mul.sv =====
module lj_mul
  import lj_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  localparam int HALF = MUL_W / 2;

  logic [MUL_W-1:0]  pp_r [4];
  logic [PROD_W-1:0] prod_r;

  // First stage: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= MUL_W'(op_a[HALF-1:0]) * MUL_W'(op_b[HALF-1:0]);
      pp_r[1] <= MUL_W'(op_a[HALF-1:0]) * MUL_W'(op_b[MUL_W-1:HALF]);
      pp_r[2] <= MUL_W'(op_a[MUL_W-1:HALF]) * MUL_W'(op_b[HALF-1:0]);
      pp_r[3] <= MUL_W'(op_a[MUL_W-1:HALF]) * MUL_W'(op_b[MUL_W-1:HALF]);
    end
  end

  // Second stage: align and sum the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{MUL_W{1'b0}}, pp_r[0]}
              + {{HALF{1'b0}}, pp_r[1], {HALF{1'b0}}}
              + {{HALF{1'b0}}, pp_r[2], {HALF{1'b0}}}
              + {pp_r[3], {MUL_W{1'b0}}};
    end
  end

  assign prod = prod_r;

endmodule

// ===== src/lj_div.sv =====
module lj_div
  import lj_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [R_W-1:0]       den_i,
  input  logic [R_W-1:0]       rem_i,
  input  logic [DIV_STEPS-1:0] num_i,
  output logic [DIV_STEPS-1:0] quo_o
);

  logic [R_W-1:0]       den_r [DIV_STEPS];
  logic [R_W-1:0]       rem_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] num_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS];

  // Restoring division, one quotient bit per stage. The running remainder
  // stays below the divisor whenever the starting remainder does, so it fits the divisor width.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [R_W-1:0]       den_in;
    logic [R_W-1:0]       rem_in;
    logic [DIV_STEPS-1:0] num_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [R_W:0]         trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign rem_in = rem_i;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign den_in = den_r[k-1];
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, num_in[DIV_STEPS-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        rem_r[k] <= take ? R_W'(trial - {1'b0, den_in}) : trial[R_W-1:0];
        num_r[k] <= num_in << 1;
        quo_r[k] <= {quo_in[DIV_STEPS-2:0], take};
      end
    end
  end

  assign quo_o = quo_r[DIV_STEPS-1];

endmodule

// ===== src/lennard_jones_pair_kernel.sv =====
// Channel   Direction  Beat contents (lowest bit first)
// in_       slave      tdata: dist_squared[31:0]
// out_      master     tdata: pair_energy[47:0], force_over_r[47:0]
//                      tuser: beyond_cutoff, clipped
// cfg_      write      cfg_index selects the register, cfg_wdata its value
//
// The two 62-step divider pipelines (sigma^2/r2 and the force divide) make up most
// of the register stages between an accepted input beat and its output beat.
// One beat per cycle is accepted while the output is taken or empty.
// A stall on the output freezes every stage; nothing is lost or repeated.
// Reset clears the valid chain and loads the register defaults.
module lennard_jones_pair_kernel
  import lj_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [R_W-1:0]       in_tdata,   // dist_squared
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*OUT_W-1:0]   out_tdata,  // pair_energy, force_over_r
  output logic [1:0]           out_tuser,  // beyond_cutoff, clipped
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [OUT_W-1:0]     cfg_wdata
);

  logic [R_W-1:0]   well_r;
  logic [R_W-1:0]   size_r;
  logic [R_W-1:0]   cut_r;
  logic [OUT_W-1:0] offs_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      well_r <= R_W'(1) << FRAC_BITS;
      size_r <= R_W'(1) << FRAC_BITS;
      cut_r  <= R_W'((25 << FRAC_BITS) / 4);
      offs_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WELL_DEPTH:     well_r <= cfg_wdata[R_W-1:0];
        REG_SIZE_SQUARED:   size_r <= cfg_wdata[R_W-1:0];
        REG_CUTOFF_SQUARED: cut_r  <= cfg_wdata[R_W-1:0];
        REG_ENERGY_OFFSET:  offs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Cap a shifted product to POW_LIMIT; the top bit reports the cap.
  function automatic logic [POW_W:0] cap_pow(input logic [PROD_W-1:0] p);
    logic hit;
    hit = |p[PROD_W-1:POW_W+FRAC_BITS];
    return hit ? {1'b1, POW_LIMIT} : {1'b0, p[POW_W+FRAC_BITS-1:FRAC_BITS]};
  endfunction

  // Whole pipeline advances together; the last stage is the output register.
  logic                 en;
  logic [TOTAL_LAT-1:0] vld_r;

  assign en        = !vld_r[TOTAL_LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_tvalid};
    end
  end

  // Input stage: range checks on r2.
  item_t t0_r;
  item_t t0_nxt;

  always_comb begin
    t0_nxt        = '0;
    t0_nxt.r2     = in_tdata;
    t0_nxt.beyond = in_tdata >= cut_r;
    t0_nxt.zero   = in_tdata == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= t0_nxt;
    end
  end

  // s = (sigma^2 << F) / r2, padded so the divider returns extra low bits.
  logic [DIV_STEPS-1:0] quo1;
  item_t                da_r [DIV_STEPS];

  lj_div u_div_s (
    .clk   (clk),
    .en    (en),
    .den_i (t0_r.r2),
    .rem_i ('0),
    .num_i (DIV_STEPS'({size_r, {FRAC_BITS{1'b0}}}) << S_PAD),
    .quo_o (quo1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      da_r[0] <= t0_r;
      for (int i = 1; i < DIV_STEPS; i++) begin
        da_r[i] <= da_r[i-1];
      end
    end
  end

  item_t it_a;
  always_comb begin
    it_a   = da_r[DIV_STEPS-1];
    it_a.s = quo1[DIV_STEPS-1:S_PAD];
  end

  // s2 = s*s >> F.
  logic [PROD_W-1:0] p1;
  item_t             db_r [MUL_LAT];

  lj_mul u_mul_s2 (
    .clk (clk), .en (en),
    .op_a (MUL_W'(it_a.s)), .op_b (MUL_W'(it_a.s)), .prod (p1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      db_r[0] <= it_a;
      for (int i = 1; i < MUL_LAT; i++) begin
        db_r[i] <= db_r[i-1];
      end
    end
  end

  logic [POW_W:0] s2_c;
  item_t          it_b;
  always_comb begin
    s2_c      = cap_pow(p1);
    it_b      = db_r[MUL_LAT-1];
    it_b.over = it_b.over | s2_c[POW_W];
  end

  // s3 = s2*s >> F.
  logic [PROD_W-1:0] p2;
  item_t             dc_r [MUL_LAT];

  lj_mul u_mul_s3 (
    .clk (clk), .en (en),
    .op_a (MUL_W'(s2_c[POW_W-1:0])), .op_b (MUL_W'(it_b.s)), .prod (p2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0] <= it_b;
      for (int i = 1; i < MUL_LAT; i++) begin
        dc_r[i] <= dc_r[i-1];
      end
    end
  end

  logic [POW_W:0] s3_c;
  item_t          it_c;
  always_comb begin
    s3_c      = cap_pow(p2);
    it_c      = dc_r[MUL_LAT-1];
    it_c.over = it_c.over | s3_c[POW_W];
    it_c.s3   = s3_c[POW_W-1:0];
  end

  // s6 = s3*s3 >> F.
  logic [PROD_W-1:0] p3;
  item_t             dd_r [MUL_LAT];

  lj_mul u_mul_s6 (
    .clk (clk), .en (en),
    .op_a (MUL_W'(it_c.s3)), .op_b (MUL_W'(it_c.s3)), .prod (p3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0] <= it_c;
      for (int i = 1; i < MUL_LAT; i++) begin
        dd_r[i] <= dd_r[i-1];
      end
    end
  end

  // Differences s6-s3 and 2*s6-s3 as sign and magnitude.
  logic [POW_W:0]          s6_c;
  logic signed [MUL_W-1:0] de;
  logic signed [MUL_W-1:0] df;
  item_t                   t5_nxt;
  item_t                   t5_r;

  always_comb begin
    s6_c         = cap_pow(p3);
    t5_nxt       = dd_r[MUL_LAT-1];
    t5_nxt.over  = t5_nxt.over | s6_c[POW_W];
    de           = $signed({2'b00, s6_c[POW_W-1:0]}) - $signed({2'b00, t5_nxt.s3});
    df           = $signed({1'b0, s6_c[POW_W-1:0], 1'b0}) - $signed({2'b00, t5_nxt.s3});
    t5_nxt.neg_e = de[MUL_W-1];
    t5_nxt.neg_f = df[MUL_W-1];
    t5_nxt.me    = de[MUL_W-1] ? MAG_W'(-de) : de[MAG_W-1:0];
    t5_nxt.mf    = df[MUL_W-1] ? MAG_W'(-df) : df[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_r <= t5_nxt;
    end
  end

  // Energy term 4*eps*me and force numerator 24*eps*mf.
  logic [PROD_W-1:0] pe;
  logic [PROD_W-1:0] pf;
  logic [MUL_W-1:0]  eps_x;
  item_t             de_r [MUL_LAT];

  assign eps_x = MUL_W'(well_r);

  lj_mul u_mul_e (
    .clk (clk), .en (en),
    .op_a (eps_x << 2), .op_b (MUL_W'(t5_r.me)), .prod (pe)
  );

  lj_mul u_mul_f (
    .clk (clk), .en (en),
    .op_a ((eps_x << 4) + (eps_x << 3)), .op_b (MUL_W'(t5_r.mf)), .prod (pf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      de_r[0] <= t5_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        de_r[i] <= de_r[i-1];
      end
    end
  end

  // Cap the energy term; check whether the force quotient would exceed the cap.
  item_t                t7_nxt;
  item_t                t7_r;
  logic [POW_W:0]       te_c;
  logic [R_W-1:0]       t7_rem_r;
  logic [DIV_STEPS-1:0] t7_num_r;

  always_comb begin
    te_c        = cap_pow(pe);
    t7_nxt      = de_r[MUL_LAT-1];
    t7_nxt.te   = te_c[POW_W-1:0];
    t7_nxt.capf = pf[PROD_W-1:DIV_STEPS] >= (PROD_W - DIV_STEPS)'(t7_nxt.r2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t7_r     <= t7_nxt;
      t7_rem_r <= pf[DIV_STEPS+R_W-1:DIV_STEPS];
      t7_num_r <= pf[DIV_STEPS-1:0];
    end
  end

  // Force quotient divided by r2.
  logic [DIV_STEPS-1:0] quo2;
  item_t                dfr_r [DIV_STEPS];

  lj_div u_div_f (
    .clk   (clk),
    .en    (en),
    .den_i (t7_r.r2),
    .rem_i (t7_rem_r),
    .num_i (t7_num_r),
    .quo_o (quo2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dfr_r[0] <= t7_r;
      for (int i = 1; i < DIV_STEPS; i++) begin
        dfr_r[i] <= dfr_r[i-1];
      end
    end
  end

  // Apply signs and subtract the energy offset.
  item_t                   it_f;
  logic [POW_W-1:0]        tf;
  logic signed [MUL_W-1:0] offs_x;
  logic signed [MUL_W-1:0] ve;
  logic signed [MUL_W-1:0] vf;
  item_t                   t9_r;
  logic signed [MUL_W-1:0] e9_r;
  logic signed [MUL_W-1:0] f9_r;

  always_comb begin
    it_f   = dfr_r[DIV_STEPS-1];
    tf     = it_f.capf ? POW_LIMIT : quo2;
    offs_x = {{(MUL_W-OUT_W){offs_r[OUT_W-1]}}, offs_r};
    ve     = it_f.neg_e ? -$signed({2'b00, it_f.te}) : $signed({2'b00, it_f.te});
    vf     = it_f.neg_f ? -$signed({2'b00, tf}) : $signed({2'b00, tf});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t9_r <= it_f;
      e9_r <= ve - offs_x;
      f9_r <= vf;
    end
  end

  // Output stage: clamps and special cases.
  logic signed [MUL_W-1:0] neg_offs;
  logic [OUT_W-1:0]        e_out;
  logic [OUT_W-1:0]        f_out;
  logic                    clip_out;
  logic [OUT_W-1:0]        out_e_r;
  logic [OUT_W-1:0]        out_f_r;
  logic                    out_beyond_r;
  logic                    out_clip_r;

  always_comb begin
    neg_offs = -offs_x;
    e_out    = '0;
    f_out    = '0;
    clip_out = 1'b0;
    priority if (t9_r.beyond) begin
      e_out = '0;
    end else if (t9_r.zero || (t9_r.over && well_r != '0)) begin
      e_out    = OUT_MAX[OUT_W-1:0];
      f_out    = OUT_MAX[OUT_W-1:0];
      clip_out = 1'b1;
    end else if (t9_r.over) begin
      if (neg_offs > OUT_MAX) begin
        e_out    = OUT_MAX[OUT_W-1:0];
        clip_out = 1'b1;
      end else begin
        e_out = neg_offs[OUT_W-1:0];
      end
    end else begin
      if (e9_r > OUT_MAX) begin
        e_out    = OUT_MAX[OUT_W-1:0];
        clip_out = 1'b1;
      end else if (e9_r < OUT_MIN) begin
        e_out    = OUT_MIN[OUT_W-1:0];
        clip_out = 1'b1;
      end else begin
        e_out = e9_r[OUT_W-1:0];
      end
      if (f9_r > OUT_MAX) begin
        f_out    = OUT_MAX[OUT_W-1:0];
        clip_out = 1'b1;
      end else if (f9_r < OUT_MIN) begin
        f_out    = OUT_MIN[OUT_W-1:0];
        clip_out = 1'b1;
      end else begin
        f_out = f9_r[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_e_r      <= e_out;
      out_f_r      <= f_out;
      out_beyond_r <= t9_r.beyond;
      out_clip_r   <= clip_out;
    end
  end

  assign out_tvalid = vld_r[TOTAL_LAT-1];
  assign out_tdata  = {out_f_r, out_e_r};
  assign out_tuser  = {out_clip_r, out_beyond_r};

endmodule
